### hw/rtl/snu_pkg.sv
// Shared types, codes and helpers for the spiking neuron update block.
// No dependencies; every other file of the block uses this package.
package snu_pkg;

  // Field and register widths fixed by the interface.
  localparam int REQ_W    = 2;
  localparam int CUR_W    = 24;
  localparam int POT_W    = 32;
  localparam int RATE_W   = 17;
  localparam int SENS_W   = 17;
  localparam int RPOT_W   = 24;
  localparam int JUMP_W   = 22;
  localparam int BIAS_W   = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier: 33-bit signed operands cover the potential, the
  // recovery difference and every coefficient.
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_RESTART = 2'd2
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPOT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS  = 3'd4;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_H_SQ   = 13'b0000000000010,
    ST_H_SQS  = 13'b0000000000100,
    ST_H_Q    = 13'b0000000001000,
    ST_H_V    = 13'b0000000010000,
    ST_R_BV   = 13'b0000000100000,
    ST_R_DIFF = 13'b0000001000000,
    ST_R_A    = 13'b0000010000000,
    ST_R_U    = 13'b0000100000000,
    ST_SPIKE  = 13'b0001000000000,
    ST_RS_MUL = 13'b0010000000000,
    ST_RS_U   = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [POT_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sd2147483647);
    lo = -PROD_W'(64'sd2147483648);
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[POT_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/snu_if.sv
// Handshake channels of the spiking neuron update block: requests in,
// potential and spike flag out. Depends on snu_pkg for field widths.
interface snu_in_if;
  logic                              valid;
  logic                              ready;
  logic [snu_pkg::REQ_W-1:0]         req_type;
  logic signed [snu_pkg::CUR_W-1:0]  current_value;

  modport source (output valid, output req_type, output current_value, input ready);
  modport sink   (input valid, input req_type, input current_value, output ready);
endinterface

interface snu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [snu_pkg::POT_W-1:0]  potential;
  logic                              fired;

  modport source (output valid, output potential, output fired, input ready);
  modport sink   (input valid, input potential, input fired, output ready);
endinterface

### hw/rtl/snu_mul.sv
// Shared signed multiplier with a registered product and a floor shift
// by the fraction width. Depends on snu_pkg for operand widths.
module snu_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic signed [snu_pkg::OP_W-1:0]    a,
  input  logic signed [snu_pkg::OP_W-1:0]    b,
  output logic signed [snu_pkg::PROD_W-1:0]  q
);
  import snu_pkg::*;

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Arithmetic shift of a two's complement value rounds toward minus infinity.
  assign q = prod >>> FRAC_BITS;

endmodule

### hw/rtl/spiking_neuron_update.sv
// Top level of the spiking neuron update block: sequencer, neuron state
// and configuration registers. Depends on snu_pkg, snu_if and snu_mul.
//
// Usage. Requests arrive as words on in_ch: req_type 0 advances the neuron by
// one millisecond, 1 loads current_value as the drive current, 2 restarts the
// neuron from the configuration registers, and 3 leaves the state alone. Each
// request answers with exactly one word on out_ch carrying the membrane
// potential and the spike flag after the request.
// Timing. All multiplications go through one shared multiplier with a
// registered product, so each product is issued and read in separate states.
// An advance runs two half-steps of the potential, the recovery update, the
// spike test and the output hand-over; a restart runs a product, the state
// update and the hand-over, and a load or no-op goes straight to the hand-over.
// in_ch.ready is high only while the sequencer is idle, so no new request is
// taken until the last one has been handed to the output register.
// Stalls. The result sits in an output register; a new request is accepted
// while an earlier word still waits, and the sequencer holds its finished
// result until the output register is free.
// Reset. rst is synchronous and active high. It loads the default
// coefficients and puts the neuron in its restart state; no clearing pass.
// Configuration writes via cfg_write/cfg_index/cfg_data are taken at any edge
// and are meant to be issued only while the block is idle.
module spiking_neuron_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [snu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [snu_pkg::CFG_W-1:0]             cfg_data,
  snu_in_if.sink                                in_ch,
  snu_out_if.source                             out_ch
);
  import snu_pkg::*;

  // Fixed-point constants follow the fraction width.
  localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
  localparam logic signed [OP_W-1:0]   K_004 = OP_W'((4 * ONE_Q + 50) / 100);
  localparam logic signed [PROD_W-1:0] K_140 = PROD_W'(140 * ONE_Q);
  localparam logic signed [PROD_W-1:0] K_30  = PROD_W'(30 * ONE_Q);

  // Register defaults, truncated to the register widths.
  localparam logic [RATE_W-1:0]        RST_RATE = RATE_W'((2 * ONE_Q + 50) / 100);
  localparam logic [SENS_W-1:0]        RST_SENS = SENS_W'((20 * ONE_Q + 50) / 100);
  localparam logic signed [RPOT_W-1:0] RST_RPOT = RPOT_W'(-(65 * ONE_Q));
  localparam logic [JUMP_W-1:0]        RST_JUMP = JUMP_W'(8 * ONE_Q);
  localparam longint RST_BC =
    (longint'(RST_SENS) * longint'(RST_RPOT)) >>> FRAC_BITS;
  localparam logic signed [POT_W-1:0]  RST_REC = sat32(PROD_W'(RST_BC));

  // Configuration registers.
  logic [RATE_W-1:0]        recovery_rate;
  logic [SENS_W-1:0]        recovery_sensitivity;
  logic signed [RPOT_W-1:0] reset_potential;
  logic [JUMP_W-1:0]        recovery_jump;
  logic signed [BIAS_W-1:0] bias_current;

  // Neuron state.
  logic signed [POT_W-1:0]  membrane_potential;
  logic signed [POT_W-1:0]  recovery_level;
  logic                     spike_flag;
  logic signed [POT_W-1:0]  drive_current;

  // Sequencer and intermediate values.
  state_t                   state;
  logic                     second_half;
  logic signed [PROD_W-1:0] half_base;
  logic signed [POT_W-1:0]  square;
  logic signed [OP_W-1:0]   rec_diff;

  // Output register.
  logic                     out_valid;
  logic signed [POT_W-1:0]  out_potential;
  logic                     out_fired;

  // Shared multiplier.
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_q;

  logic signed [PROD_W-1:0] half_sum;
  logic signed [POT_W-1:0]  potential_half_next;
  logic                     out_free;
  logic                     in_take;

  snu_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .q  (mul_q)
  );

  // The operands are chosen by the state that issues each product; the
  // product is read in the state that follows.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_H_SQ: begin
        mul_a = OP_W'(membrane_potential);
        mul_b = OP_W'(membrane_potential);
      end
      ST_H_Q: begin
        mul_a = OP_W'(square);
        mul_b = K_004;
      end
      ST_R_BV: begin
        mul_a = $signed({{(OP_W - SENS_W){1'b0}}, recovery_sensitivity});
        mul_b = OP_W'(membrane_potential);
      end
      ST_R_A: begin
        mul_a = $signed({{(OP_W - RATE_W){1'b0}}, recovery_rate});
        mul_b = rec_diff;
      end
      ST_RS_MUL: begin
        mul_a = $signed({{(OP_W - SENS_W){1'b0}}, recovery_sensitivity});
        mul_b = OP_W'(reset_potential);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // End of a half-step: the quadratic term joins the precomputed linear
  // terms, and half of the sum is added to the potential.
  assign half_sum            = mul_q + half_base;
  assign potential_half_next = sat32(PROD_W'(membrane_potential) + (half_sum >>> 1));

  assign out_free = !out_valid || out_ch.ready;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.potential = out_potential;
  assign out_ch.fired     = out_fired;

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_rate        <= RST_RATE;
      recovery_sensitivity <= RST_SENS;
      reset_potential      <= RST_RPOT;
      recovery_jump        <= RST_JUMP;
      bias_current         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RATE: recovery_rate        <= cfg_data[RATE_W-1:0];
        CFG_SENS: recovery_sensitivity <= cfg_data[SENS_W-1:0];
        CFG_RPOT: reset_potential      <= $signed(cfg_data[RPOT_W-1:0]);
        CFG_JUMP: recovery_jump        <= cfg_data[JUMP_W-1:0];
        CFG_BIAS: bias_current         <= $signed(cfg_data[BIAS_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      second_half        <= 1'b0;
      out_valid          <= 1'b0;
      membrane_potential <= POT_W'(RST_RPOT);
      recovery_level     <= RST_REC;
      spike_flag         <= 1'b0;
      drive_current      <= '0;
    end else begin
      // In the done state the output register is refilled below instead.
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (in_ch.req_type)
              REQ_ADVANCE: begin
                second_half <= 1'b0;
                state       <= ST_H_SQ;
              end
              REQ_LOAD: begin
                drive_current <= POT_W'(in_ch.current_value);
                state         <= ST_DONE;
              end
              REQ_RESTART: begin
                state <= ST_RS_MUL;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_H_SQ: begin
          // Linear part of the half-step while the square is formed.
          half_base <= (PROD_W'(membrane_potential) <<< 2) + PROD_W'(membrane_potential)
                       + K_140 - PROD_W'(recovery_level) + PROD_W'(drive_current);
          state     <= ST_H_SQS;
        end
        ST_H_SQS: begin
          square <= sat32(mul_q);
          state  <= ST_H_Q;
        end
        ST_H_Q: begin
          state <= ST_H_V;
        end
        ST_H_V: begin
          membrane_potential <= potential_half_next;
          second_half        <= 1'b1;
          state              <= second_half ? ST_R_BV : ST_H_SQ;
        end
        ST_R_BV: begin
          state <= ST_R_DIFF;
        end
        ST_R_DIFF: begin
          rec_diff <= OP_W'(sat32(mul_q)) - OP_W'(recovery_level);
          state    <= ST_R_A;
        end
        ST_R_A: begin
          state <= ST_R_U;
        end
        ST_R_U: begin
          recovery_level <= sat32(PROD_W'(recovery_level) + mul_q);
          state          <= ST_SPIKE;
        end
        ST_SPIKE: begin
          if (PROD_W'(membrane_potential) > K_30) begin
            spike_flag         <= 1'b1;
            membrane_potential <= POT_W'(reset_potential);
            recovery_level     <= sat32(PROD_W'(recovery_level)
                                        + $signed({{(PROD_W - JUMP_W){1'b0}}, recovery_jump}));
          end else begin
            spike_flag    <= 1'b0;
            drive_current <= POT_W'(bias_current);
          end
          state <= ST_DONE;
        end
        ST_RS_MUL: begin
          state <= ST_RS_U;
        end
        ST_RS_U: begin
          membrane_potential <= POT_W'(reset_potential);
          recovery_level     <= sat32(mul_q);
          spike_flag         <= 1'b0;
          drive_current      <= POT_W'(bias_current);
          state              <= ST_DONE;
        end
        ST_DONE: begin
          // Hand the result over once the output register is free.
          if (out_free) begin
            out_valid     <= 1'b1;
            out_potential <= membrane_potential;
            out_fired     <= spike_flag;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
